FILE: rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

   localparam int FracBits   = 14;
   localparam int DataW      = 16;
   localparam int RadW       = 32;
   localparam int RootW      = 16;
   localparam int NumW       = DataW + 1;
   localparam int DvdW       = NumW + FracBits;
   localparam int SqrtStages = RootW / 2;
   localparam int DivStages  = DataW / 2;

   typedef enum logic [1:0] {
      BR_TRACE,
      BR_COL0,
      BR_COL1,
      BR_COL2
   } branch_type;

   typedef struct packed {
      branch_type            branch;
      logic [1:0]            big;
      logic [3:0][NumW-1:0]  num;
   } meta_type;

   typedef struct packed {
      branch_type       branch;
      logic [1:0]       big;
      logic             degen;
      logic [3:0]       neg;
      logic [3:0]       ovf;
      logic [DataW-1:0] half;
   } dmeta_type;

endpackage
`default_nettype wire

FILE: rtl/core/rmq_ifs.sv
// Request and response channel interfaces of the quaternion unit.
// Depends on rmq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface rmq_req_if;
   import rmq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2;
   modport source (output valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2,
                   input ready);
   modport sink (input valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2,
                 output ready);
endinterface

interface rmq_rsp_if;
   import rmq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] quat_x, quat_y, quat_z, quat_w;
   logic [1:0]              branch_taken;
   logic                    degenerate;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                   input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rmq_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Depends on rmq_pkg; carries request metadata alongside.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [RadW-1:0]  in_rad,
   input  wire meta_type         in_meta,
   output logic                  out_valid,
   output logic [RootW-1:0]      out_root,
   output meta_type              out_meta
);

   logic [SqrtStages-1:0] v_ff;
   logic [RadW-1:0]       rem_ff [SqrtStages];
   logic [RadW-1:0]       res_ff [SqrtStages];
   meta_type              meta_ff [SqrtStages];
   logic [RadW-1:0]       rem_in [SqrtStages];
   logic [RadW-1:0]       res_in [SqrtStages];

   always_comb begin
      logic [RadW-1:0] r;
      logic [RadW-1:0] q;
      logic [RadW-1:0] b;
      for (int s = 0; s < SqrtStages; s++) begin
         r = (s == 0) ? in_rad : rem_ff[s-1];
         q = (s == 0) ? '0 : res_ff[s-1];
         for (int j = 0; j < 2; j++) begin
            b = RadW'(1) << (RadW - 2 - 4*s - 2*j);
            if (r >= q + b) begin
               r = r - (q + b);
               q = (q >> 1) + b;
            end else begin
               q = q >> 1;
            end
         end
         rem_in[s] = r;
         res_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[SqrtStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SqrtStages; s++) begin
            rem_ff[s]  <= rem_in[s];
            res_ff[s]  <= res_in[s];
            meta_ff[s] <= (s == 0) ? in_meta : meta_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[SqrtStages-1];
   assign out_root  = res_ff[SqrtStages-1][RootW-1:0];
   assign out_meta  = meta_ff[SqrtStages-1];

endmodule
`default_nettype wire

FILE: rtl/core/rmq_div.sv
// Four-lane pipelined restoring divider, two quotient bits per stage.
// Depends on rmq_pkg; carries divider metadata alongside.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div import rmq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [3:0][DvdW-1:0]   in_dvd,
   input  wire logic [NumW-1:0]        in_dvs,
   input  wire dmeta_type              in_meta,
   output logic                        out_valid,
   output logic [3:0][DataW-1:0]       out_quo,
   output dmeta_type                   out_meta
);

   localparam int TrialW = NumW + DataW;

   logic [DivStages-1:0]     v_ff;
   logic [3:0][DvdW-1:0]     rem_ff [DivStages];
   logic [3:0][DataW-1:0]    quo_ff [DivStages];
   logic [NumW-1:0]          dvs_ff [DivStages];
   dmeta_type                meta_ff [DivStages];
   logic [3:0][DvdW-1:0]     rem_in [DivStages];
   logic [3:0][DataW-1:0]    quo_in [DivStages];

   always_comb begin
      logic [DvdW-1:0]   r;
      logic [DataW-1:0]  q;
      logic [NumW-1:0]   d;
      logic [TrialW-1:0] trial;
      int                k;
      for (int s = 0; s < DivStages; s++) begin
         d = (s == 0) ? in_dvs : dvs_ff[s-1];
         for (int l = 0; l < 4; l++) begin
            r = (s == 0) ? in_dvd[l] : rem_ff[s-1][l];
            q = (s == 0) ? '0 : quo_ff[s-1][l];
            for (int j = 0; j < 2; j++) begin
               k = DataW - 1 - 2*s - j;
               trial = TrialW'(d) << k;
               if (TrialW'(r) >= trial) begin
                  r = DvdW'(TrialW'(r) - trial);
                  q[k] = 1'b1;
               end
            end
            rem_in[s][l] = r;
            quo_in[s][l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DivStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DivStages; s++) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            dvs_ff[s]  <= (s == 0) ? in_dvs : dvs_ff[s-1];
            meta_ff[s] <= (s == 0) ? in_meta : meta_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[DivStages-1];
   assign out_quo   = quo_ff[DivStages-1];
   assign out_meta  = meta_ff[DivStages-1];

endmodule
`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion_unit.sv
// Top level: Shepperd rotation matrix to quaternion conversion, signed Q1.14.
// Depends on rmq_pkg, rmq_ifs, rmq_sqrt and rmq_div.
//
// One request enters every cycle when the pipeline is not held, and its
// response leaves after one input stage for branch selection, 8 square root
// stages, one operand stage, 8 divider stages and the response register. The
// whole pipeline holds when a response waits and rsp_chan.ready is low, so
// throughput is one matrix per cycle under a ready consumer.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rmq_req_if.sink   req_chan,
   rmq_rsp_if.source rsp_chan
);

   localparam int TW = DataW + 2;

   logic en;

   // input stage
   logic             s0_v_ff;
   logic [RadW-1:0]  s0_rad_ff, s0_rad_in;
   meta_type         s0_meta_ff, s0_meta_in;

   logic             sq_v;
   logic [RootW-1:0] sq_root;
   meta_type         sq_meta;

   // operand stage
   logic               p_v_ff;
   logic [3:0][DvdW-1:0] p_dvd_ff, p_dvd_in;
   logic [NumW-1:0]    p_dvs_ff, p_dvs_in;
   dmeta_type          p_meta_ff, p_meta_in;

   logic                  dv_v;
   logic [3:0][DataW-1:0] dv_quo;
   dmeta_type             dv_meta;

   logic                  out_v_ff;
   logic [3:0][DataW-1:0] out_q_ff, out_q_in;
   branch_type            out_br_ff;
   logic                  out_dg_ff;

   assign en           = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      logic signed [TW-1:0] d0, d1, d2, d4, d5, d6, d8, d9, d10, one, tt, t;
      d0  = TW'(req_chan.r0c0);
      d1  = TW'(req_chan.r1c0);
      d2  = TW'(req_chan.r2c0);
      d4  = TW'(req_chan.r0c1);
      d5  = TW'(req_chan.r1c1);
      d6  = TW'(req_chan.r2c1);
      d8  = TW'(req_chan.r0c2);
      d9  = TW'(req_chan.r1c2);
      d10 = TW'(req_chan.r2c2);
      one = TW'(1) <<< FracBits;
      tt  = one + d0 + d5 + d10;
      s0_meta_in.num = '0;
      if (tt > 0) begin
         t = tt;
         s0_meta_in.branch = BR_TRACE;
         s0_meta_in.big    = 2'd3;
         s0_meta_in.num[0] = NumW'(d9 - d6);
         s0_meta_in.num[1] = NumW'(d2 - d8);
         s0_meta_in.num[2] = NumW'(d4 - d1);
      end else if (d0 > d5 && d0 > d10) begin
         t = one + d0 - d5 - d10;
         s0_meta_in.branch = BR_COL0;
         s0_meta_in.big    = 2'd0;
         s0_meta_in.num[1] = NumW'(d4 + d1);
         s0_meta_in.num[2] = NumW'(d2 + d8);
         s0_meta_in.num[3] = NumW'(d9 - d6);
      end else if (d5 > d10) begin
         t = one + d5 - d0 - d10;
         s0_meta_in.branch = BR_COL1;
         s0_meta_in.big    = 2'd1;
         s0_meta_in.num[0] = NumW'(d4 + d1);
         s0_meta_in.num[2] = NumW'(d9 + d6);
         s0_meta_in.num[3] = NumW'(d2 - d8);
      end else begin
         t = one + d10 - d0 - d5;
         s0_meta_in.branch = BR_COL2;
         s0_meta_in.big    = 2'd2;
         s0_meta_in.num[0] = NumW'(d2 + d8);
         s0_meta_in.num[1] = NumW'(d9 + d6);
         s0_meta_in.num[3] = NumW'(d4 - d1);
      end
      s0_rad_in = (t > 0) ? (RadW'(t[TW-2:0]) << FracBits) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         p_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff  <= req_chan.valid;
         p_v_ff   <= sq_v;
         out_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_rad_ff  <= s0_rad_in;
         s0_meta_ff <= s0_meta_in;
         p_dvd_ff   <= p_dvd_in;
         p_dvs_ff   <= p_dvs_in;
         p_meta_ff  <= p_meta_in;
         out_q_ff   <= out_q_in;
         out_br_ff  <= dv_meta.branch;
         out_dg_ff  <= dv_meta.degen;
      end
   end

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_v_ff),
      .in_rad    (s0_rad_ff),
      .in_meta   (s0_meta_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_meta  (sq_meta)
   );

   always_comb begin
      logic signed [NumW-1:0] n;
      logic [NumW-1:0]        mag;
      logic [RootW:0]         rp1;
      p_dvs_in          = {sq_root, 1'b0};
      rp1               = {1'b0, sq_root} + (RootW+1)'(1);
      p_meta_in.branch  = sq_meta.branch;
      p_meta_in.big     = sq_meta.big;
      p_meta_in.degen   = (sq_root == '0);
      p_meta_in.half    = rp1[RootW:1];
      for (int i = 0; i < 4; i++) begin
         n   = $signed(sq_meta.num[i]);
         mag = (n < 0) ? NumW'(-n) : NumW'(n);
         p_meta_in.neg[i] = (n < 0);
         p_dvd_in[i]      = (DvdW'(mag) << FracBits) + DvdW'(sq_root);
         p_meta_in.ovf[i] = NumW'(p_dvd_in[i][DvdW-1:DataW]) >= p_dvs_in;
      end
   end

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_v_ff),
      .in_dvd    (p_dvd_ff),
      .in_dvs    (p_dvs_ff),
      .in_meta   (p_meta_ff),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_meta  (dv_meta)
   );

   always_comb begin
      logic [DataW-1:0] q;
      for (int i = 0; i < 4; i++) begin
         q = dv_quo[i];
         if (dv_meta.degen) begin
            out_q_in[i] = '0;
         end else if (dv_meta.big == 2'(i)) begin
            out_q_in[i] = dv_meta.half;
         end else if (!dv_meta.neg[i]) begin
            out_q_in[i] = (dv_meta.ovf[i] || q[DataW-1]) ? {1'b0, {(DataW-1){1'b1}}} : q;
         end else begin
            out_q_in[i] = (dv_meta.ovf[i] || (q[DataW-1] && q[DataW-2:0] != '0)) ?
                          {1'b1, {(DataW-1){1'b0}}} : DataW'(-q);
         end
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.quat_x       = out_q_ff[0];
   assign rsp_chan.quat_y       = out_q_ff[1];
   assign rsp_chan.quat_z       = out_q_ff[2];
   assign rsp_chan.quat_w       = out_q_ff[3];
   assign rsp_chan.branch_taken = out_br_ff;
   assign rsp_chan.degenerate   = out_dg_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_dg_ff |-> out_q_ff == '0)
      else $error("degenerate response with nonzero components");

   a_trace_nondegen: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_br_ff == BR_TRACE |-> !out_dg_ff)
      else $error("trace branch flagged degenerate");

   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_br_ff == BR_TRACE |-> $signed(out_q_ff[3]) > 0)
      else $error("trace branch with nonpositive w");

endmodule
`default_nettype wire
